// ----- hdl/csp_pkg.sv -----
// Shared types and constants for the cron schedule parser.
package csp_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned NUM_FIELDS_DEF  = 5;
    localparam int unsigned VALUE_LIMIT_DEF = 60;

    // Fixed payload widths
    localparam int unsigned CH_W    = 8;
    localparam int unsigned FIELD_W = 3;
    localparam int unsigned VALUE_W = 6;

    // Character codes
    localparam logic [CH_W-1:0] CH_EOT   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CH_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    // Token kinds
    typedef enum logic [2:0] {
        TK_ANY   = 3'd0,
        TK_EXACT = 3'd1,
        TK_LIST  = 3'd2,
        TK_RLOW  = 3'd3,
        TK_RHIGH = 3'd4
    } t_tok_kind;

    // Field mode inside one field
    typedef enum logic [1:0] {
        MODE_FIRST = 2'd0,
        MODE_LIST  = 2'd1,
        MODE_RANGE = 2'd2
    } t_field_mode;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            first;
    } t_csp_in;

    typedef struct packed {
        logic [FIELD_W-1:0] field_index;
        t_tok_kind          token_kind;
        logic [VALUE_W-1:0] token_value;
        logic               field_end;
        logic               parse_error;
        logic               schedule_done;
    } t_csp_out;

endpackage

// ----- hdl/cron_schedule_parser_unit.sv -----
// Cron schedule parser: one character per beat in, at most one token per beat out.
// An accepted character beat goes through the input register, then through the parse logic
// into the result register, which presents its token beat.
// Throughput: one character per cycle; the result register sets the pace under stall.
// Reset: synchronous, active low; clears both valid flags and returns the parser to idle.
// A character that arrives without first while idle, done or in error gives no token.
module cron_schedule_parser_unit #(
    parameter int unsigned NUM_FIELDS  = csp_pkg::NUM_FIELDS_DEF,
    parameter int unsigned VALUE_LIMIT = csp_pkg::VALUE_LIMIT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  csp_pkg::t_csp_in i_in,
    output logic             o_valid,
    input  logic             i_ready,
    output csp_pkg::t_csp_out o_out
);

    localparam int unsigned ACC_W  = $clog2(VALUE_LIMIT + 1);
    localparam int unsigned PROD_W = ACC_W + 4;
    localparam int unsigned FW     = csp_pkg::FIELD_W;
    localparam logic [ACC_W-1:0]  LIMIT_ACC  = ACC_W'(VALUE_LIMIT);
    localparam logic [PROD_W-1:0] LIMIT_PROD = PROD_W'(VALUE_LIMIT);
    localparam logic [FW-1:0]     LAST_FIELD = FW'(NUM_FIELDS - 1);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_NUMBER = 3'd2,
        PH_DONE   = 3'd3,
        PH_ERROR  = 3'd4
    } t_phase;

    // Registers
    logic                  r_in_valid,  n_in_valid;
    csp_pkg::t_csp_in      r_in,        n_in;
    logic                  r_out_valid, n_out_valid;
    csp_pkg::t_csp_out     r_out,       n_out;
    t_phase                r_phase,     n_phase;
    logic [FW-1:0]         r_fc,        n_fc;
    logic [ACC_W-1:0]      r_acc,       n_acc;
    logic                  r_ds,        n_ds;
    csp_pkg::t_field_mode  r_mode,      n_mode;

    logic out_free;
    logic proc;

    // Advance the input register whenever the result register can take its token
    assign out_free = !r_out_valid || i_ready;
    assign proc     = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;
    assign o_valid  = r_out_valid;
    assign o_out    = r_out;

    // Hold a new beat in the input register
    always_comb begin
        n_in       = r_in;
        n_in_valid = r_in_valid;
        if (proc) begin
            n_in_valid = 1'b0;
        end
        if (i_valid && o_ready) begin
            n_in_valid = 1'b1;
            n_in       = i_in;
        end
    end

    // Parse one character
    always_comb begin
        t_phase               ph;
        logic [FW-1:0]        fc;
        logic [ACC_W-1:0]     acc;
        logic                 ds;
        csp_pkg::t_field_mode md;
        logic [7:0]           c;
        logic                 is_digit;
        logic                 is_blank;
        logic                 is_eot;
        logic                 last;
        logic [PROD_W-1:0]    dval;
        logic [PROD_W-1:0]    prod;
        logic                 fin;
        csp_pkg::t_tok_kind   fin_kind;
        logic                 err;
        logic                 tok;
        csp_pkg::t_tok_kind   tok_kind;
        logic [ACC_W-1:0]     tok_val;
        logic                 tok_end;
        logic                 tok_done;

        c        = r_in.ch;
        is_digit = (c >= csp_pkg::CH_ZERO) && (c <= csp_pkg::CH_NINE);
        is_blank = (c == csp_pkg::CH_SPACE) || (c == csp_pkg::CH_TAB);
        is_eot   = (c == csp_pkg::CH_EOT);
        dval     = PROD_W'(c[3:0]);

        // Restart on first
        if (r_in.first) begin
            ph  = PH_START;
            fc  = '0;
            acc = '0;
            ds  = 1'b0;
            md  = csp_pkg::MODE_FIRST;
        end else begin
            ph  = r_phase;
            fc  = r_fc;
            acc = r_acc;
            ds  = r_ds;
            md  = r_mode;
        end

        prod     = (PROD_W'(acc) << 3) + (PROD_W'(acc) << 1) + dval;
        last     = (fc >= LAST_FIELD);
        fin      = 1'b0;
        fin_kind = csp_pkg::TK_ANY;
        err      = 1'b0;
        tok      = 1'b0;
        tok_kind = csp_pkg::TK_ANY;
        tok_val  = acc;
        tok_end  = 1'b0;
        tok_done = 1'b0;

        n_phase = ph;
        n_fc    = fc;
        n_acc   = acc;
        n_ds    = ds;
        n_mode  = md;

        unique case (ph)
            PH_START: begin
                if (is_blank) begin
                    // skip separator
                end else if (is_eot) begin
                    err = 1'b1;
                end else if (c == csp_pkg::CH_STAR) begin
                    fin      = 1'b1;
                    fin_kind = csp_pkg::TK_ANY;
                    tok_val  = '0;
                end else if (is_digit) begin
                    n_acc   = (dval > LIMIT_PROD) ? LIMIT_ACC : ACC_W'(dval);
                    n_ds    = 1'b1;
                    n_mode  = csp_pkg::MODE_FIRST;
                    n_phase = PH_NUMBER;
                end else begin
                    err = 1'b1;
                end
            end
            PH_NUMBER: begin
                if (is_digit) begin
                    n_acc = (prod > LIMIT_PROD) ? LIMIT_ACC : ACC_W'(prod);
                    n_ds  = 1'b1;
                end else if (!ds || acc >= LIMIT_ACC) begin
                    err = 1'b1;
                end else begin
                    unique case (md)
                        csp_pkg::MODE_FIRST: begin
                            if (c == csp_pkg::CH_COMMA) begin
                                tok      = 1'b1;
                                tok_kind = csp_pkg::TK_LIST;
                                n_mode   = csp_pkg::MODE_LIST;
                                n_acc    = '0;
                                n_ds     = 1'b0;
                            end else if (c == csp_pkg::CH_DASH) begin
                                tok      = 1'b1;
                                tok_kind = csp_pkg::TK_RLOW;
                                n_mode   = csp_pkg::MODE_RANGE;
                                n_acc    = '0;
                                n_ds     = 1'b0;
                            end else if (is_blank || is_eot) begin
                                fin      = 1'b1;
                                fin_kind = csp_pkg::TK_EXACT;
                            end else begin
                                err = 1'b1;
                            end
                        end
                        csp_pkg::MODE_LIST: begin
                            if (c == csp_pkg::CH_COMMA) begin
                                tok      = 1'b1;
                                tok_kind = csp_pkg::TK_LIST;
                                n_acc    = '0;
                                n_ds     = 1'b0;
                            end else if (is_blank || is_eot) begin
                                fin      = 1'b1;
                                fin_kind = csp_pkg::TK_LIST;
                            end else begin
                                err = 1'b1;
                            end
                        end
                        default: begin
                            if (is_blank || is_eot) begin
                                fin      = 1'b1;
                                fin_kind = csp_pkg::TK_RHIGH;
                            end else begin
                                err = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default: begin
                // idle, done or error: drop the character
            end
        endcase

        // Close the field
        if (fin) begin
            if (is_eot && !last) begin
                err = 1'b1;
            end else begin
                tok      = 1'b1;
                tok_kind = fin_kind;
                tok_end  = 1'b1;
                tok_done = last;
                if (last) begin
                    n_phase = PH_DONE;
                end else begin
                    n_fc    = fc + 1'b1;
                    n_phase = PH_START;
                end
            end
        end

        // Build the result beat
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        if (err) begin
            n_phase = PH_ERROR;
        end
        if (proc) begin
            n_out_valid = err || tok;
            n_out       = '0;
            if (err) begin
                n_out.parse_error = 1'b1;
            end else begin
                n_out.field_index   = fc;
                n_out.token_kind    = tok_kind;
                n_out.token_value   = csp_pkg::VALUE_W'(tok_val);
                n_out.field_end     = tok_end;
                n_out.schedule_done = tok_done;
            end
        end else begin
            n_phase = r_phase;
            n_fc    = r_fc;
            n_acc   = r_acc;
            n_ds    = r_ds;
            n_mode  = r_mode;
        end
    end

    // Hold state, input beat and result beat
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_fc        <= '0;
            r_acc       <= '0;
            r_ds        <= 1'b0;
            r_mode      <= csp_pkg::MODE_FIRST;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
            r_fc        <= n_fc;
            r_acc       <= n_acc;
            r_ds        <= n_ds;
            r_mode      <= n_mode;
        end
    end

    // An error beat carries nothing else
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.parse_error |-> o_out.field_index == '0
            && o_out.token_value == '0 && !o_out.field_end && !o_out.schedule_done)
        else $error("error beat carries token data");

    // Done only on the closing token of the final field
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.schedule_done |-> o_out.field_end
            && o_out.field_index == LAST_FIELD)
        else $error("done outside final field end");

    // Field index stays within the schedule
    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.parse_error |-> o_out.field_index <= LAST_FIELD)
        else $error("field index out of range");

    // Nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_in_valid)
        else $error("beat present after reset");

endmodule

// ----- bench/tb_cron_schedule_parser_unit.sv -----
`timescale 1ns / 1ps
// Testbench for the cron schedule parser: a directed table, then random schedules checked against a predictor.
module tb_cron_schedule_parser_unit;

    localparam int unsigned FIELD_COUNT     = csp_pkg::NUM_FIELDS_DEF;
    localparam int unsigned NUM_LIMIT       = csp_pkg::VALUE_LIMIT_DEF;
    localparam int unsigned LIVE_BEATS_GOAL = 550;
    localparam int unsigned CYCLE_LIMIT     = 300000;
    localparam int unsigned DRAIN_CYCLES    = 16;
    localparam int unsigned RESET_CYCLES    = 11;
    localparam logic [csp_pkg::CH_W-1:0] CH_LOWER_A  = 8'h61;
    localparam logic [csp_pkg::CH_W-1:0] CH_ALL_ONES = 8'hFF;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_NUMBER,
        PH_DONE,
        PH_ERROR
    } t_parse_phase;

    // How a stimulus beat is checked: by the predictor, as silent, or against a typed token
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_QUIET,
        ROW_TOKEN
    } t_row_check;

    typedef struct packed {
        csp_pkg::t_csp_in  beat;
        t_row_check        check;
        csp_pkg::t_csp_out tok;
    } t_dir_row;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    csp_pkg::t_csp_in  i_in    = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    csp_pkg::t_csp_out o_out;

    // Parser state as the predictor tracks it
    t_parse_phase                parse_phase = PH_IDLE;
    logic [csp_pkg::FIELD_W-1:0] field_idx   = '0;
    int unsigned                 num_acc     = 0;
    bit                          have_digit  = 1'b0;
    csp_pkg::t_field_mode        field_mode  = csp_pkg::MODE_FIRST;

    csp_pkg::t_csp_out        reject_beat;
    csp_pkg::t_csp_out        expected_tokens[$];
    t_row_check               row_checks[$];
    csp_pkg::t_csp_out        row_tokens[$];
    t_dir_row                 dir_rows[$];
    logic [csp_pkg::CH_W-1:0] sched_text[$];
    bit                       steady_burst = 1'b0;
    int unsigned              hold_cycles  = 0;
    int unsigned              taken_count  = 0;
    int unsigned              served_count = 0;
    int unsigned              live_beats   = 0;
    int unsigned              fail_count   = 0;
    int unsigned              cycle_count  = 0;

    cron_schedule_parser_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic csp_pkg::t_csp_out token_of(input logic [csp_pkg::FIELD_W-1:0] fi,
                                                   input csp_pkg::t_tok_kind kind,
                                                   input int unsigned value, input logic fend,
                                                   input logic done);
        csp_pkg::t_csp_out t;
        t = '0;
        t.field_index   = fi;
        t.token_kind    = kind;
        t.token_value   = value[csp_pkg::VALUE_W-1:0];
        t.field_end     = fend;
        t.schedule_done = done;
        return t;
    endfunction

    function automatic csp_pkg::t_csp_out reject();
        parse_phase = PH_ERROR;
        return reject_beat;
    endfunction

    // Emit the last token of the field; early end of text before the final field is rejected
    function automatic csp_pkg::t_csp_out close_field(input csp_pkg::t_tok_kind kind,
                                                      input int unsigned value,
                                                      input logic [csp_pkg::CH_W-1:0] c);
        csp_pkg::t_csp_out t;
        bit                last;
        last = (field_idx >= FIELD_COUNT - 1);
        if (c == csp_pkg::CH_EOT && !last) return reject();
        t = token_of(field_idx, kind, value, 1'b1, last);
        if (last) begin
            parse_phase = PH_DONE;
        end else begin
            field_idx   = field_idx + 1'b1;
            parse_phase = PH_START;
        end
        return t;
    endfunction

    // Advance the predicted parser by one character; return 1 when it yields a token or an error beat
    function automatic bit parse_char(input csp_pkg::t_csp_in beat,
                                      output csp_pkg::t_csp_out tok);
        logic [csp_pkg::CH_W-1:0] c;
        bit                       blank;
        bit                       digit;
        int unsigned              v;
        c     = beat.ch;
        blank = (c == csp_pkg::CH_SPACE) || (c == csp_pkg::CH_TAB);
        digit = (c >= csp_pkg::CH_ZERO) && (c <= csp_pkg::CH_NINE);
        tok   = '0;
        if (beat.first) begin
            parse_phase = PH_START;
            field_idx   = '0;
            num_acc     = 0;
            have_digit  = 1'b0;
            field_mode  = csp_pkg::MODE_FIRST;
        end

        // Field start: skip blanks, take '*' or the first digit, reject anything else
        if (parse_phase == PH_START) begin
            if (blank) return 1'b0;
            if (c == csp_pkg::CH_EOT) begin
                tok = reject();
                return 1'b1;
            end
            if (c == csp_pkg::CH_STAR) begin
                tok = close_field(csp_pkg::TK_ANY, 0, c);
                return 1'b1;
            end
            if (digit) begin
                v           = {24'd0, c - csp_pkg::CH_ZERO};
                num_acc     = (v > NUM_LIMIT) ? NUM_LIMIT : v;
                have_digit  = 1'b1;
                field_mode  = csp_pkg::MODE_FIRST;
                parse_phase = PH_NUMBER;
                return 1'b0;
            end
            tok = reject();
            return 1'b1;
        end

        if (parse_phase != PH_NUMBER) return 1'b0;

        // Accumulate digits, saturating at the value limit
        if (digit) begin
            v          = num_acc * 10 + {24'd0, c - csp_pkg::CH_ZERO};
            num_acc    = (v > NUM_LIMIT) ? NUM_LIMIT : v;
            have_digit = 1'b1;
            return 1'b0;
        end

        if (!have_digit || num_acc >= NUM_LIMIT) begin
            tok = reject();
            return 1'b1;
        end
        v = num_acc;

        // Decide the token from the separator and the position in the field
        case (field_mode)
            csp_pkg::MODE_FIRST: begin
                if (c == csp_pkg::CH_COMMA) begin
                    field_mode = csp_pkg::MODE_LIST;
                    num_acc    = 0;
                    have_digit = 1'b0;
                    tok        = token_of(field_idx, csp_pkg::TK_LIST, v, 1'b0, 1'b0);
                end else if (c == csp_pkg::CH_DASH) begin
                    field_mode = csp_pkg::MODE_RANGE;
                    num_acc    = 0;
                    have_digit = 1'b0;
                    tok        = token_of(field_idx, csp_pkg::TK_RLOW, v, 1'b0, 1'b0);
                end else if (blank || c == csp_pkg::CH_EOT) begin
                    tok = close_field(csp_pkg::TK_EXACT, v, c);
                end else begin
                    tok = reject();
                end
            end
            csp_pkg::MODE_LIST: begin
                if (c == csp_pkg::CH_COMMA) begin
                    num_acc    = 0;
                    have_digit = 1'b0;
                    tok        = token_of(field_idx, csp_pkg::TK_LIST, v, 1'b0, 1'b0);
                end else if (blank || c == csp_pkg::CH_EOT) begin
                    tok = close_field(csp_pkg::TK_LIST, v, c);
                end else begin
                    tok = reject();
                end
            end
            default: begin
                if (blank || c == csp_pkg::CH_EOT) tok = close_field(csp_pkg::TK_RHIGH, v, c);
                else tok = reject();
            end
        endcase
        return 1'b1;
    endfunction

    function automatic int unsigned field_diff(input string name, input logic [7:0] want,
                                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    function automatic logic [csp_pkg::CH_W-1:0] dig(input int unsigned n);
        return csp_pkg::CH_ZERO + n[csp_pkg::CH_W-1:0];
    endfunction

    task automatic add_row(input logic [csp_pkg::CH_W-1:0] c, input logic first,
                           input t_row_check check, input csp_pkg::t_csp_out tok);
        t_dir_row r;
        r.beat.ch    = c;
        r.beat.first = first;
        r.check      = check;
        r.tok        = tok;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    // Drive one character beat after a random gap (none in a steady burst) and hold it until accepted
    task automatic send_char(input logic [csp_pkg::CH_W-1:0] c, input logic first,
                             input t_row_check check, input csp_pkg::t_csp_out typed);
        csp_pkg::t_csp_in b;
        int unsigned      gap;
        gap = steady_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        b.ch    = c;
        b.first = first;
        row_checks.insert(row_checks.size(), check);
        row_tokens.insert(row_tokens.size(), typed);
        i_in    <= b;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    function automatic int unsigned pick_value();
        case ($urandom_range(0, 19))
            0: return 0;
            1: return NUM_LIMIT - 1;
            2: return NUM_LIMIT;
            3: return $urandom_range(NUM_LIMIT, 999);
            default: return $urandom_range(0, NUM_LIMIT - 1);
        endcase
    endfunction

    // Append one character to the schedule text
    task automatic add_text(input logic [csp_pkg::CH_W-1:0] c);
        sched_text.insert(sched_text.size(), c);
    endtask

    task automatic push_blanks(input int unsigned n);
        repeat (n) add_text($urandom_range(0, 1) ? csp_pkg::CH_SPACE : csp_pkg::CH_TAB);
    endtask

    task automatic push_number(input int unsigned v);
        logic [csp_pkg::CH_W-1:0] digits[$];
        if ($urandom_range(0, 7) == 0) add_text(csp_pkg::CH_ZERO);
        do begin
            digits.push_front(dig(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[k]) add_text(digits[k]);
    endtask

    // Build one schedule of random content; break about a quarter of them
    task automatic build_schedule();
        int unsigned f;
        int unsigned pos;
        bit          after_star;
        sched_text.delete();
        after_star = 1'b0;
        push_blanks($urandom_range(0, 2));
        for (f = 0; f < FIELD_COUNT; f++) begin
            if (f != 0) push_blanks(after_star ? $urandom_range(0, 3) : $urandom_range(1, 3));
            after_star = 1'b0;
            case ($urandom_range(0, 3))
                0: begin
                    add_text(csp_pkg::CH_STAR);
                    after_star = 1'b1;
                end
                1: push_number(pick_value());
                2: begin
                    push_number(pick_value());
                    repeat ($urandom_range(1, 3)) begin
                        add_text(csp_pkg::CH_COMMA);
                        push_number(pick_value());
                    end
                end
                default: begin
                    push_number(pick_value());
                    add_text(csp_pkg::CH_DASH);
                    push_number(pick_value());
                end
            endcase
        end
        if ($urandom_range(0, 1)) add_text(csp_pkg::CH_EOT);
        else push_blanks(1);
        repeat ($urandom_range(0, 3)) add_text(8'($urandom_range(0, 255)));

        if ($urandom_range(0, 3) == 0) begin
            pos = $urandom_range(0, sched_text.size() - 1);
            case ($urandom_range(0, 2))
                0: sched_text[pos] = 8'($urandom_range(0, 255));
                1: begin
                    while (sched_text.size() > pos) sched_text.delete(sched_text.size() - 1);
                    add_text(csp_pkg::CH_EOT);
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0: sched_text.insert(pos, csp_pkg::CH_COMMA);
                        1: sched_text.insert(pos, csp_pkg::CH_DASH);
                        default: sched_text.insert(pos, csp_pkg::CH_STAR);
                    endcase
                end
            endcase
        end
    endtask

    // Receiver: hold ready low for the drawn number of cycles after each token beat
    always @(negedge i_clk) begin
        if (taken_count != served_count) begin
            served_count = taken_count;
            hold_cycles  = steady_burst ? 0 : $urandom_range(0, 7);
        end
        if (hold_cycles != 0) begin
            i_ready     <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Predict on accepted character beats, compare accepted token beats
    always @(posedge i_clk) begin : check_beats
        csp_pkg::t_csp_out predicted;
        csp_pkg::t_csp_out want;
        csp_pkg::t_csp_out typed;
        t_row_check        check;
        bit                has_token;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                check = row_checks.pop_front();
                typed = row_tokens.pop_front();
                live_beats++;
                has_token = parse_char(i_in, predicted);
                if (check == ROW_TOKEN) begin
                    expected_tokens.insert(expected_tokens.size(), typed);
                end else if (check == ROW_PREDICT && has_token) begin
                    expected_tokens.insert(expected_tokens.size(), predicted);
                end
            end
            if (o_valid && i_ready) begin
                taken_count++;
                if (expected_tokens.size() == 0) begin
                    $error("token beat with no token expected");
                    fail_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    fail_count += field_diff("field_index", want.field_index, o_out.field_index);
                    fail_count += field_diff("token_kind", want.token_kind, o_out.token_kind);
                    fail_count += field_diff("token_value", want.token_value, o_out.token_value);
                    fail_count += field_diff("field_end", want.field_end, o_out.field_end);
                    fail_count += field_diff("parse_error", want.parse_error, o_out.parse_error);
                    fail_count += field_diff("schedule_done", want.schedule_done,
                                             o_out.schedule_done);
                end
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned k;
        reject_beat             = '0;
        reject_beat.parse_error = 1'b1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle, every token kind, values at both extremes, then several error cases
        add_row(dig(5),      1'b0, ROW_QUIET,   '0);
        add_row(csp_pkg::CH_STAR,  1'b1, ROW_TOKEN,
                token_of(0, csp_pkg::TK_ANY, 0, 1'b1, 1'b0));
        add_row(csp_pkg::CH_SPACE, 1'b0, ROW_PREDICT, '0);
        add_row(dig(5),      1'b0, ROW_PREDICT, '0);
        add_row(dig(9),      1'b0, ROW_PREDICT, '0);
        add_row(csp_pkg::CH_COMMA, 1'b0, ROW_TOKEN,
                token_of(1, csp_pkg::TK_LIST, 59, 1'b0, 1'b0));
        add_row(dig(0),      1'b0, ROW_PREDICT, '0);
        add_row(csp_pkg::CH_TAB,   1'b0, ROW_TOKEN,
                token_of(1, csp_pkg::TK_LIST, 0, 1'b1, 1'b0));
        add_row(dig(7),      1'b0, ROW_PREDICT, '0);
        add_row(csp_pkg::CH_DASH,  1'b0, ROW_TOKEN,
                token_of(2, csp_pkg::TK_RLOW, 7, 1'b0, 1'b0));
        add_row(dig(1),      1'b0, ROW_PREDICT, '0);
        add_row(dig(2),      1'b0, ROW_PREDICT, '0);
        add_row(csp_pkg::CH_SPACE, 1'b0, ROW_TOKEN,
                token_of(2, csp_pkg::TK_RHIGH, 12, 1'b1, 1'b0));
        add_row(dig(0),      1'b0, ROW_PREDICT, '0);
        add_row(csp_pkg::CH_SPACE, 1'b0, ROW_TOKEN,
                token_of(3, csp_pkg::TK_EXACT, 0, 1'b1, 1'b0));
        add_row(dig(5),      1'b0, ROW_PREDICT, '0);
        add_row(dig(9),      1'b0, ROW_PREDICT, '0);
        add_row(csp_pkg::CH_EOT,   1'b0, ROW_TOKEN,
                token_of(4, csp_pkg::TK_EXACT, 59, 1'b1, 1'b1));
        add_row(dig(3),      1'b0, ROW_QUIET,   '0);
        add_row(dig(6),      1'b1, ROW_PREDICT, '0);
        add_row(dig(0),      1'b0, ROW_PREDICT, '0);
        add_row(csp_pkg::CH_SPACE, 1'b0, ROW_TOKEN,   reject_beat);
        add_row(CH_ALL_ONES, 1'b0, ROW_QUIET,   '0);
        add_row(CH_ALL_ONES, 1'b1, ROW_TOKEN,   reject_beat);
        add_row(csp_pkg::CH_STAR,  1'b1, ROW_TOKEN,
                token_of(0, csp_pkg::TK_ANY, 0, 1'b1, 1'b0));
        add_row(csp_pkg::CH_EOT,   1'b0, ROW_TOKEN,   reject_beat);
        add_row(dig(4),      1'b1, ROW_PREDICT, '0);
        add_row(CH_LOWER_A,  1'b0, ROW_TOKEN,   reject_beat);

        foreach (dir_rows[n]) begin
            steady_burst = ($urandom_range(0, 3) == 0);
            send_char(dir_rows[n].beat.ch, dir_rows[n].beat.first, dir_rows[n].check,
                      dir_rows[n].tok);
        end

        // Random: mostly well-formed schedules, some broken ones, some loose noise
        while (live_beats < LIVE_BEATS_GOAL) begin
            steady_burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              ROW_PREDICT, '0);
                end
            end else begin
                build_schedule();
                for (k = 0; k < sched_text.size(); k++) begin
                    send_char(sched_text[k], k == 0, ROW_PREDICT, '0);
                end
            end
        end
        i_valid <= 1'b0;

        // Drain outstanding tokens, then watch for stray beats
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
